>>> rtl/rfw_pkg.sv
// Shared types and constants for the packed 4bpp rectangle fill writer.
package rfw_pkg;

	localparam int CMD_W       = 2;
	localparam int COORD_W     = 10;
	localparam int COLOR_W     = 4;
	localparam int STRIDE_W    = 13;
	localparam int ADDR_W      = 32;
	localparam int DATA_W      = 8;
	localparam int EN_W        = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	// Wide enough to hold the largest column or row limit (4096).
	localparam int LIMIT_W     = 13;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_LINE_STRIDE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BASE  = 2'd1;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd320;
	localparam logic [ADDR_W-1:0]   BASE_RESET   = 32'd0;

	localparam logic [EN_W-1:0] EN_LOW  = 2'b01;
	localparam logic [EN_W-1:0] EN_HIGH = 2'b10;
	localparam logic [EN_W-1:0] EN_BOTH = 2'b11;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [COORD_W-1:0] left_x;
		logic [COORD_W-1:0] top_y;
		logic [COORD_W-1:0] right_x;
		logic [COORD_W-1:0] bottom_y;
		logic [COLOR_W-1:0] pixel_color;
	} rfw_cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] byte_address;
		logic [DATA_W-1:0] write_data;
		logic [EN_W-1:0]   nibble_enable;
		logic              last_write;
		logic              bad_rectangle;
	} rfw_wr_t;

	typedef struct packed {
		logic [STRIDE_W-1:0] line_stride_bytes;
		logic [ADDR_W-1:0]   frame_base_address;
	} rfw_cfg_t;

endpackage

>>> rtl/rfw_cfg_regs.sv
// Configuration registers: line stride and frame base address.
module rfw_cfg_regs
	import rfw_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output rfw_cfg_t               cfg
);

	logic [STRIDE_W-1:0] line_stride_q;
	logic [ADDR_W-1:0]   frame_base_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_stride_q <= STRIDE_RESET;
			frame_base_q  <= BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LINE_STRIDE: line_stride_q <= cfg_data[STRIDE_W-1:0];
				CFG_FRAME_BASE:  frame_base_q  <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.line_stride_bytes  = line_stride_q;
	assign cfg.frame_base_address = frame_base_q;

endmodule

>>> rtl/rfw_fill_engine.sv
// Fill state and single-pass command decode into at most one masked byte write.
module rfw_fill_engine
	import rfw_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	input  rfw_cmd_t item,
	input  logic     item_go,
	input  rfw_cfg_t cfg,
	output logic     has_result,
	output rfw_wr_t  result
);

	localparam int PROD_W = STRIDE_W + COORD_W;
	localparam logic [LIMIT_W-1:0] WIDTH_LIM  = LIMIT_W'(MAX_WIDTH);
	localparam logic [LIMIT_W-1:0] HEIGHT_LIM = LIMIT_W'(MAX_HEIGHT);

	function automatic logic [DATA_W-1:0] nib_data(input logic [COLOR_W-1:0] color,
		input logic [EN_W-1:0] en);
		nib_data = {(en[1] ? color : {COLOR_W{1'b0}}), (en[0] ? color : {COLOR_W{1'b0}})};
	endfunction

	logic               fill_active_q, fill_active_d;
	logic [COORD_W-1:0] cursor_x_q, cursor_x_d;
	logic [COORD_W-1:0] cursor_y_q, cursor_y_d;
	logic [COORD_W-1:0] rect_left_q, rect_left_d;
	logic [COORD_W-1:0] rect_right_q, rect_right_d;
	logic [COORD_W-1:0] rect_bottom_q, rect_bottom_d;
	logic [COLOR_W-1:0] fill_color_q, fill_color_d;
	logic [ADDR_W-1:0]  row_address_q, row_address_d;

	logic [PROD_W-1:0]  line_offset;
	logic [ADDR_W-1:0]  line_addr;
	logic               load_bad;
	logic               pixel_bad;
	logic [COORD_W:0]   cx_plus1;
	logic [COORD_W:0]   cx_plus2;
	logic [COORD_W:0]   cx_next;
	logic [COORD_W:0]   right_ext;
	logic [EN_W-1:0]    step_en;
	logic [EN_W-1:0]    pixel_en;

	assign line_offset = PROD_W'(cfg.line_stride_bytes) * PROD_W'(item.top_y);
	assign line_addr   = cfg.frame_base_address + ADDR_W'(line_offset);

	assign load_bad  = (item.left_x > item.right_x) || (item.top_y > item.bottom_y) ||
		(LIMIT_W'(item.right_x) >= WIDTH_LIM) || (LIMIT_W'(item.bottom_y) >= HEIGHT_LIM);
	assign pixel_bad = (LIMIT_W'(item.left_x) >= WIDTH_LIM) ||
		(LIMIT_W'(item.top_y) >= HEIGHT_LIM);
	assign pixel_en  = item.left_x[0] ? EN_LOW : EN_HIGH;

	// Pick the nibble pattern for the cursor position within the row.
	assign cx_plus1  = {1'b0, cursor_x_q} + 1'b1;
	assign cx_plus2  = {1'b0, cursor_x_q} + 2'd2;
	assign right_ext = {1'b0, rect_right_q};

	always_comb begin
		if (cursor_x_q[0]) begin
			step_en = EN_LOW;
			cx_next = cx_plus1;
		end else if (cx_plus1 <= right_ext) begin
			step_en = EN_BOTH;
			cx_next = cx_plus2;
		end else begin
			step_en = EN_HIGH;
			cx_next = cx_plus1;
		end
	end

	always_comb begin
		fill_active_d = fill_active_q;
		cursor_x_d    = cursor_x_q;
		cursor_y_d    = cursor_y_q;
		rect_left_d   = rect_left_q;
		rect_right_d  = rect_right_q;
		rect_bottom_d = rect_bottom_q;
		fill_color_d  = fill_color_q;
		row_address_d = row_address_q;
		has_result    = 1'b0;
		result        = '0;
		case (item.cmd)
			CMD_LOAD: begin
				if (load_bad) begin
					fill_active_d        = 1'b0;
					has_result           = 1'b1;
					result.bad_rectangle = 1'b1;
				end else begin
					fill_active_d = 1'b1;
					rect_left_d   = item.left_x;
					rect_right_d  = item.right_x;
					rect_bottom_d = item.bottom_y;
					cursor_x_d    = item.left_x;
					cursor_y_d    = item.top_y;
					fill_color_d  = item.pixel_color;
					row_address_d = line_addr;
				end
			end
			CMD_PIXEL: begin
				has_result = 1'b1;
				if (pixel_bad) begin
					result.bad_rectangle = 1'b1;
				end else begin
					result.byte_address  = line_addr + ADDR_W'(item.left_x[COORD_W-1:1]);
					result.write_data    = nib_data(item.pixel_color, pixel_en);
					result.nibble_enable = pixel_en;
					result.last_write    = 1'b1;
				end
			end
			CMD_STEP: begin
				if (fill_active_q) begin
					has_result           = 1'b1;
					result.byte_address  = row_address_q + ADDR_W'(cursor_x_q[COORD_W-1:1]);
					result.write_data    = nib_data(fill_color_q, step_en);
					result.nibble_enable = step_en;
					if (cx_next > right_ext) begin
						cursor_x_d = rect_left_q;
						if (cursor_y_q >= rect_bottom_q) begin
							result.last_write = 1'b1;
							fill_active_d     = 1'b0;
						end else begin
							cursor_y_d    = cursor_y_q + 1'b1;
							row_address_d = row_address_q + ADDR_W'(cfg.line_stride_bytes);
						end
					end else begin
						cursor_x_d = cx_next[COORD_W-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_active_q <= 1'b0;
			cursor_x_q    <= '0;
			cursor_y_q    <= '0;
			rect_left_q   <= '0;
			rect_right_q  <= '0;
			rect_bottom_q <= '0;
			fill_color_q  <= '0;
			row_address_q <= '0;
		end else if (item_go) begin
			fill_active_q <= fill_active_d;
			cursor_x_q    <= cursor_x_d;
			cursor_y_q    <= cursor_y_d;
			rect_left_q   <= rect_left_d;
			rect_right_q  <= rect_right_d;
			rect_bottom_q <= rect_bottom_d;
			fill_color_q  <= fill_color_d;
			row_address_q <= row_address_d;
		end
	end

endmodule

>>> rtl/packed_4bpp_rect_fill_writer.sv
// Top level of the packed 4bpp rectangle fill writer: input stage, engine, result register.
//
// Turns load, step and pixel commands for a 4-bit-per-pixel packed framebuffer into
// masked byte writes (even x in the high nibble, odd x in the low nibble, address
// base + stride*y + x/2 wrapping at 32 bits). A load stores a rectangle and gives no
// write; each step then gives the next write of the fill, row by row, flagging the
// final one with last_write; a pixel gives one nibble write at once. A load with
// swapped or out-of-range corners, or a pixel out of range, gives one write with
// bad_rectangle set and all other fields zero. Timing: one command per clock while
// the wr channel does not stall; a result passes the input register and then the
// result register before it is valid on the wr channel. The fill engine decides
// combinationally between those two registers and updates its state as the
// command leaves the input register, so a step may directly follow a load. A
// command that gives no result passes through even while the result register is
// stalled. Configuration writes are taken in any cycle; the user must change
// stride or base only while no command is in flight, the block does not enforce it.
module packed_4bpp_rect_fill_writer
	import rfw_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// command channel
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  rfw_cmd_t               cmd_item,
	// write channel
	output logic                   wr_valid,
	input  logic                   wr_stall,
	output rfw_wr_t                wr_item,
	// configuration channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	rfw_cfg_t cfg;
	rfw_cmd_t item_s1;
	logic     valid_s1;
	logic     has_result;
	rfw_wr_t  result;
	logic     wr_free;
	logic     go_s1;
	logic     wr_valid_q;
	rfw_wr_t  wr_q;

	rfw_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rfw_fill_engine #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_s1),
		.item_go    (go_s1),
		.cfg        (cfg),
		.has_result (has_result),
		.result     (result)
	);

	// The result register can take a new write when empty or being drained.
	assign wr_free = !wr_valid_q || !wr_stall;

	// Advance the held command unless its write has nowhere to go.
	assign go_s1     = valid_s1 && (!has_result || wr_free);
	assign cmd_stall = valid_s1 && !go_s1;

	// Input register: capture a new command whenever it is empty or the held one moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall) begin
			item_s1 <= cmd_item;
		end
	end

	// Result register: hold while stalled, load the engine's write when it advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else if (wr_free) begin
			wr_valid_q <= go_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_free && go_s1 && has_result) begin
			wr_q <= result;
		end
	end

	assign wr_valid = wr_valid_q;
	assign wr_item  = wr_q;

endmodule
